// ===== design/keypad_change_event_encoder_core_assert.svh =====
// Assertion macros for the keypad change-event encoder.
// No dependencies; included by keypad_change_event_encoder_core.sv.
`ifndef KEYPAD_CHANGE_EVENT_ENCODER_CORE_ASSERT_SVH
`define KEYPAD_CHANGE_EVENT_ENCODER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under synchronous active-low reset.
`define KCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keypad encoder assertion failed");
// Next-cycle implication under synchronous active-low reset.
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keypad encoder assertion failed");
`else
`define KCE_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define KCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/kce_pkg.sv =====
// Types and constants for the keypad change-event encoder.
// No dependencies; used by keypad_change_event_encoder_core.
package kce_pkg;

  localparam int unsigned NUM_LINES = 10;

  localparam logic [7:0] CH_PRESS   = 8'h50;
  localparam logic [7:0] CH_RELEASE = 8'h52;
  localparam logic [7:0] CH_NL      = 8'h0A;
  localparam logic [7:0] DIGIT_BASE = 8'h30;
  localparam logic [7:0] BYTE_ONES  = 8'hFF;

  localparam logic KIND_SERIAL = 1'b0;
  localparam logic KIND_LATCH  = 1'b1;

  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_DIGIT = 2'd1,
    PH_NL    = 2'd2,
    PH_LATCH = 2'd3
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    logic [15:0] raw_first;
    logic [15:0] raw_second;
  } scan_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic [7:0] latch_low;
    logic [7:0] latch_high;
    logic       last;
  } event_t;

endpackage

// ===== design/keypad_change_event_encoder_core.sv =====
// Keypad change-event encoder: scan debounce, change detection, event serializer.
// Depends on kce_pkg and keypad_change_event_encoder_core_assert.svh.
//
//   channel | dir | payload          | handshake
//   --------+-----+------------------+------------------------------
//   in_     | in  | scan_t (2 x 16b) | in_valid / in_stall (ours)
//   out_    | out | event_t (26b)    | out_valid / out_stall (sink)
//
// A scan is taken only in IDLE. The switch walk then visits the switches in
// order from a pair of shift registers (pressed / released) and stops after the
// highest changed switch: an unchanged switch below it emits nothing, a release
// emits three events and a press four, and the walk then returns to IDLE.
// in_stall is therefore high from when a scan is taken until the walk is back
// in IDLE, output stall time included, so no new scan is taken mid-walk.
// Reset (synchronous, rst_n low) clears the held switch state and the walk.
// out_stall holds the output register; the walk waits until it can load it.
module keypad_change_event_encoder_core #(
  parameter int NUM_SWITCHES = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  kce_pkg::scan_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output kce_pkg::event_t out_data
);
  import kce_pkg::*;

`include "keypad_change_event_encoder_core_assert.svh"

  // Switches above the keypad size stay in the held state but never report.
  localparam int Lim = (NUM_SWITCHES > 10) ? 10 : NUM_SWITCHES;
  localparam logic [NUM_LINES-1:0] RptMask = NUM_LINES'((1 << Lim) - 1);

  state_t                 state_r, state_nxt;
  logic [NUM_LINES-1:0]   held_r, held_nxt;
  logic [NUM_LINES-1:0]   on_sr_r, on_sr_nxt;
  logic [NUM_LINES-1:0]   off_sr_r, off_sr_nxt;
  logic [3:0]             idx_r, idx_nxt;
  phase_t                 phase_r, phase_nxt;
  logic                   out_valid_r, out_valid_nxt;
  event_t                 out_data_r, out_data_nxt;

  logic [NUM_LINES-1:0]   now_w;
  logic [NUM_LINES-1:0]   diff_w;
  logic                   out_free;
  logic                   rest_empty;
  logic                   is_press;
  phase_t                 final_ph;
  logic [15:0]            led_pat;
  logic                   emit;
  event_t                 res;
  logic [15:0]            latch_pat;
  logic                   latch_out_w;
  logic                   latch_ok_w;

  // Debounce: a switch is pressed only if both active-low samples agree.
  assign now_w      = ~in_data.raw_first[NUM_LINES-1:0] & ~in_data.raw_second[NUM_LINES-1:0];
  assign diff_w     = now_w ^ held_r;
  assign out_free   = !out_valid_r || !out_stall;
  assign rest_empty = ((on_sr_r | off_sr_r) >> 1) == '0;
  assign is_press   = on_sr_r[0];
  assign final_ph   = is_press ? PH_LATCH : PH_NL;
  assign led_pat    = 16'd1 << idx_r;

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    on_sr_nxt  = on_sr_r;
    off_sr_nxt = off_sr_r;
    idx_nxt    = idx_r;
    phase_nxt  = phase_r;
    emit       = 1'b0;
    res        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // Load the change masks and take the new pattern as held state.
          held_nxt   = now_w;
          on_sr_nxt  = diff_w & now_w & RptMask;
          off_sr_nxt = diff_w & held_r & RptMask;
          idx_nxt    = '0;
          phase_nxt  = PH_LEAD;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((on_sr_r | off_sr_r) == '0) begin
          state_nxt = ST_IDLE;
        end else if (!on_sr_r[0] && !off_sr_r[0]) begin
          // Skip an unchanged switch.
          on_sr_nxt  = on_sr_r >> 1;
          off_sr_nxt = off_sr_r >> 1;
          idx_nxt    = idx_r + 4'd1;
        end else if (out_free) begin
          emit = 1'b1;
          unique case (phase_r)
            PH_LEAD: begin
              res.kind    = KIND_SERIAL;
              res.tx_byte = is_press ? CH_PRESS : CH_RELEASE;
            end
            PH_DIGIT: begin
              res.kind    = KIND_SERIAL;
              res.tx_byte = DIGIT_BASE + {4'd0, idx_r};
            end
            PH_NL: begin
              res.kind    = KIND_SERIAL;
              res.tx_byte = CH_NL;
            end
            PH_LATCH: begin
              res.kind       = KIND_LATCH;
              res.latch_low  = led_pat[7:0] ^ BYTE_ONES;
              res.latch_high = led_pat[15:8] ^ BYTE_ONES;
            end
            default: begin
              res = '0;
            end
          endcase
          if (phase_r == final_ph) begin
            // Advance to the next switch after the last byte of this event.
            res.last   = rest_empty;
            on_sr_nxt  = on_sr_r >> 1;
            off_sr_nxt = off_sr_r >> 1;
            idx_nxt    = idx_r + 4'd1;
            phase_nxt  = PH_LEAD;
          end else begin
            phase_nxt = phase_t'(phase_r + 2'd1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop when the sink takes the transaction.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      on_sr_r     <= '0;
      off_sr_r    <= '0;
      idx_r       <= '0;
      phase_r     <= PH_LEAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      on_sr_r     <= on_sr_nxt;
      off_sr_r    <= off_sr_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign latch_pat   = ~{out_data_r.latch_high, out_data_r.latch_low};
  assign latch_out_w = out_valid_r && (out_data_r.kind == KIND_LATCH);
  assign latch_ok_w  = $onehot(latch_pat) && (out_data_r.tx_byte == '0);

  // Held state only changes when a scan is taken.
  `KCE_ASSERT_NXT(a_held_stable, clk, rst_n, state_r == ST_SCAN, $stable(held_r))
  // The result flagged last leaves no pending events behind it.
  `KCE_ASSERT_NXT(a_last_drains, clk, rst_n, emit && res.last, (on_sr_r | off_sr_r) == '0)
  // A latch write lights exactly one LED and carries no serial byte.
  `KCE_ASSERT_NOW(a_latch_onehot, clk, rst_n, latch_out_w, latch_ok_w)

endmodule

// ===== tb/sv/kce_event_checker.sv =====
// Result checker for the keypad change-event encoder: predicts and compares events.
// Depends on kce_pkg; instantiated beside the block by keypad_change_event_encoder_core_tb.
module kce_event_checker #(
  parameter int NUM_SWITCHES = 10
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  kce_pkg::scan_t  in_data,
  input  logic            out_valid,
  input  logic            out_stall,
  input  kce_pkg::event_t out_data,
  output int              fail_count,
  output int              events_due
);
  import kce_pkg::*;

  localparam int WALK_LINES = (NUM_SWITCHES > 10) ? 10 : NUM_SWITCHES;

  logic [9:0] held_lines;
  event_t     pending_events[$];
  int         failures;

  initial begin
    failures   = 0;
    fail_count = 0;
    events_due = 0;
    held_lines = '0;
  end

  function automatic event_t serial_event(input logic [7:0] b);
    event_t ev;
    ev = '0;
    ev.kind    = KIND_SERIAL;
    ev.tx_byte = b;
    return ev;
  endfunction

  // Walk the switches in order and queue the events this scan causes.
  task automatic queue_scan_events(input scan_t s);
    logic [9:0]  now_lines;
    logic [9:0]  rising;
    logic [9:0]  falling;
    logic [15:0] one_hot;
    event_t      ev;
    int          first_new;
    now_lines = ~s.raw_first[9:0] & ~s.raw_second[9:0];
    rising    = now_lines & ~held_lines;
    falling   = held_lines & ~now_lines;
    first_new = pending_events.size();
    for (int i = 0; i < WALK_LINES; i++) begin
      if (rising[i]) begin
        pending_events.push_back(serial_event(CH_PRESS));
        pending_events.push_back(serial_event(DIGIT_BASE + 8'(i)));
        pending_events.push_back(serial_event(CH_NL));
        one_hot       = 16'd1 << i;
        ev            = '0;
        ev.kind       = KIND_LATCH;
        ev.latch_low  = ~one_hot[7:0];
        ev.latch_high = ~one_hot[15:8];
        pending_events.push_back(ev);
      end else if (falling[i]) begin
        pending_events.push_back(serial_event(CH_RELEASE));
        pending_events.push_back(serial_event(DIGIT_BASE + 8'(i)));
        pending_events.push_back(serial_event(CH_NL));
      end
    end
    if (pending_events.size() > first_new) begin
      ev      = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
    held_lines = now_lines;
  endtask

  task automatic note_failure(input string what, input event_t want, input event_t got);
    failures++;
    if (failures <= 10)
      $display("%0t: %s: expected kind=%0b tx=%h lo=%h hi=%h last=%0b,",
               $realtime, what, want.kind, want.tx_byte, want.latch_low,
               want.latch_high, want.last,
               " got kind=%0b tx=%h lo=%h hi=%h last=%0b",
               got.kind, got.tx_byte, got.latch_low, got.latch_high, got.last);
  endtask

  always @(posedge clk) begin
    event_t want;
    if (!rst_n) begin
      pending_events.delete();
      held_lines = '0;
    end else begin
      if (in_valid && !in_stall)
        queue_scan_events(in_data);
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          note_failure("unexpected event", '0, out_data);
        end else begin
          want = pending_events.pop_front();
          if (out_data.kind !== want.kind || out_data.tx_byte !== want.tx_byte ||
              out_data.latch_low !== want.latch_low ||
              out_data.latch_high !== want.latch_high || out_data.last !== want.last)
            note_failure("event mismatch", want, out_data);
        end
      end
    end
    fail_count <= failures;
    events_due <= pending_events.size();
  end

endmodule

// ===== tb/sv/keypad_change_event_encoder_core_tb.sv =====
// Testbench top for keypad_change_event_encoder_core: clock, reset, scan stimulus, verdict.
// Depends on kce_pkg, the block and kce_event_checker.
module keypad_change_event_encoder_core_tb;
  import kce_pkg::*;

  localparam int SWITCH_COUNT = 10;
  localparam int PHASE_ITEMS  = 110;

  logic   clk;
  logic   rst_n;
  logic   in_valid;
  logic   in_stall;
  scan_t  in_data;
  logic   out_valid;
  logic   out_stall = 1'b0;
  event_t out_data;

  int fail_count;
  int events_due;

  // Idle and stall odds, in percent, for the current phase.
  int in_idle_pct;
  int out_stall_pct;

  // Debounced pattern the block will hold once every scan so far is taken.
  logic [9:0] tracked_lines;

  keypad_change_event_encoder_core #(
    .NUM_SWITCHES(SWITCH_COUNT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  kce_event_checker #(
    .NUM_SWITCHES(SWITCH_COUNT)
  ) i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .events_due(events_due)
  );

  always #5 clk = ~clk;

  // Stall the result channel at random; the decision changes only at the falling edge.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < out_stall_pct);
  end

  // Hard stop: far beyond the slowest legal run (every scan 40 events, heavy stalling).
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Both samples agree exactly: the pattern is pressed, everything else released.
  function automatic scan_t clean_scan(input logic [15:0] pressed);
    return scan_t'{raw_first: ~pressed, raw_second: ~pressed};
  endfunction

  // Add bounce: extra lines low in only one of the two samples, which debounce drops.
  function automatic scan_t bouncy_scan(input logic [15:0] pressed);
    logic [15:0] glitch_a;
    logic [15:0] glitch_b;
    glitch_a = 16'($urandom) & 16'($urandom) & ~pressed;
    glitch_b = 16'($urandom) & ~pressed & ~glitch_a;
    return scan_t'{raw_first: ~(pressed | glitch_a), raw_second: ~(pressed | glitch_b)};
  endfunction

  // Present one scan transaction; start and end at a falling edge.
  // Hold the payload until the block takes it; valid never looks at stall.
  task automatic drive_scan(input scan_t s);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    tracked_lines = ~s.raw_first[9:0] & ~s.raw_second[9:0];
    @(negedge clk);
  endtask

  // Mostly small edits of the held pattern, some fresh patterns and some raw noise.
  task automatic drive_random_scans(input int count);
    logic [9:0]  next_lines;
    logic [15:0] beyond;
    int          pick;
    for (int n = 0; n < count; n++) begin
      pick   = $urandom_range(99);
      beyond = {6'($urandom), 10'd0};
      if (pick < 70) begin
        next_lines = tracked_lines;
        case ($urandom_range(9))
          0: ;                                              // no change
          1: next_lines = ~tracked_lines;                   // flip every switch
          2, 3: begin
            next_lines[$urandom_range(9)] ^= 1'b1;
            next_lines[$urandom_range(9)] ^= 1'b1;
            next_lines[$urandom_range(9)] ^= 1'b1;
          end
          default: next_lines[$urandom_range(9)] ^= 1'b1;
        endcase
        drive_scan(($urandom_range(1) == 0) ? clean_scan(beyond | next_lines)
                                             : bouncy_scan(beyond | next_lines));
      end else if (pick < 85) begin
        drive_scan(bouncy_scan(beyond | 16'(10'($urandom))));
      end else begin
        drive_scan(scan_t'{raw_first: 16'($urandom), raw_second: 16'($urandom)});
      end
    end
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    tracked_lines = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed scans, back to back with no idling.
    drive_scan(clean_scan(16'h0000));                      // nothing pressed after reset
    drive_scan(clean_scan(16'h0001));                      // press switch 0
    drive_scan(clean_scan(16'h0001));                      // no change: no events
    drive_scan(clean_scan(16'h0000));                      // release switch 0
    drive_scan(clean_scan(16'hFFFF));                      // press all: forty events
    drive_scan(clean_scan(16'hFC00));                      // release all; lines past keypad ignored
    drive_scan(scan_t'{raw_first: 16'h0000, raw_second: 16'hFFFF}); // first sample only
    drive_scan(scan_t'{raw_first: 16'hFFFF, raw_second: 16'h0000}); // second sample only
    drive_scan(clean_scan(16'h0200));                      // switch 9 lights latch B
    drive_scan(clean_scan(16'h0100));                      // press 8, release 9
    drive_scan(clean_scan(16'h0080));                      // switch 7: top bit of latch A
    drive_scan(clean_scan(16'h0155));                      // presses and releases interleave
    drive_scan(clean_scan(16'h02AA));
    drive_scan(clean_scan(16'h03FF));
    drive_scan(scan_t'{raw_first: 16'hAAAA, raw_second: 16'h5555}); // disjoint: all released
    drive_scan(clean_scan(16'h0000));                      // no change

    // Random scans across idling phases: none, sender idle, receiver stall, both.
    drive_random_scans(PHASE_ITEMS);
    in_idle_pct = 61;
    drive_random_scans(PHASE_ITEMS);
    in_idle_pct   = 0;
    out_stall_pct = 61;
    drive_random_scans(PHASE_ITEMS);
    in_idle_pct   = 9;
    out_stall_pct = 9;
    drive_random_scans(PHASE_ITEMS);
    in_valid <= 1'b0;

    // Drain: wait for every predicted event, then let a full walk's worth pass.
    while (events_due != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (events_due != 0)
      $display("%0d predicted events never arrived", events_due);
    if (fail_count == 0 && events_due == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
